/* src/adc_frame_check_offset_calibrate_defines.svh */
// assertion macros for the converter word check block
// used by the top level only, no other dependencies
`ifndef ADC_FRAME_CHECK_OFFSET_CALIBRATE_DEFINES_SVH
`define ADC_FRAME_CHECK_OFFSET_CALIBRATE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define AFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afc assertion failed");

// next-cycle implication, reset masks the check
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afc assertion failed");

`endif

/* src/afc_pkg.sv */
// shared widths, codes and types for the converter word check block
// no dependencies
package afc_pkg;

    localparam int CHAN_W      = 4;
    localparam int FRAME_W     = 32;
    localparam int VALUE_W     = 26;
    localparam int OFS_W       = 25;
    localparam int SUM_W       = 33;
    localparam int QUOT_W      = SUM_W + 1;
    localparam int CMD_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = 8;
    localparam int RETRY_W     = 4;
    localparam int ERR_W       = 5;
    localparam int ADDR_W      = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_DATA_W  = 8;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RETRY      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PARITY     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ADDR       = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CAL_SAMPLE = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_CAL_DONE   = 3'd5;

    localparam logic REG_RETRY_LIMIT = 1'b0;
    localparam logic REG_CAL_COUNT   = 1'b1;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
    localparam logic [CNT_W-1:0]   CAL_COUNT_RST   = 8'd16;

    localparam logic [2:0] CMD_PREFIX = 3'b101;

    localparam logic signed [QUOT_W-1:0] OFS_MAX = 34'sd16777215;
    localparam logic signed [QUOT_W-1:0] OFS_MIN = -34'sd16777216;
    localparam logic signed [QUOT_W-1:0] SUM_MAX = 34'sd4294967295;
    localparam logic signed [QUOT_W-1:0] SUM_MIN = -34'sd4294967296;

    typedef struct packed {
        logic                      parity_err;
        logic                      addr_err;
        logic [ADDR_W-1:0]         addr;
        logic signed [VALUE_W-1:0] reading;
    } check_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* src/adc_frame_check_offset_calibrate.sv */
// Converter result word check with per-channel offset calibration. Each
// input word is checked for even parity and for the address of the
// requested channel, decoded into a signed reading and corrected by the
// channel's stored offset; calibration words are summed and their average
// becomes the channel offset. A word passes from acceptance through the EVAL
// and PUT states to the output register; a word that completes a channel
// calibration also waits in the DIV state for the serial divider, which forms
// one quotient bit per cycle over the 33-bit sum. The block takes one word
// at a time, ready again once its result is loaded; a new word is accepted
// while the previous result still waits on the output. The offset table
// holds 16 entries that reset clears to zero at once.
// depends on afc_pkg, afc_check, afc_div and the assertion macro header
`include "adc_frame_check_offset_calibrate_defines.svh"

module adc_frame_check_offset_calibrate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // channel [3:0], frame [35:4], zero fill
    input  logic [afc_pkg::S_TDATA_W-1:0]         s_tdata,
    // func [0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // value [25:0], command_byte [33:26], zero fill
    output logic [afc_pkg::M_TDATA_W-1:0]         m_tdata,
    // status [2:0]
    output logic [afc_pkg::STATUS_W-1:0]          m_tuser
);
    import afc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [RETRY_W-1:0]        retry_limit_reg;
    logic [CNT_W-1:0]          cal_count_reg;
    logic [ERR_W-1:0]          err_tries_reg, err_tries_next;
    logic signed [SUM_W-1:0]   cal_sum_reg, cal_sum_next;
    logic [CNT_W-1:0]          cal_samples_reg, cal_samples_next;
    logic signed [VALUE_W-1:0] last_good_reg, last_good_next;
    logic signed [OFS_W-1:0]   offset_reg [16];

    logic                      func_reg;
    logic [CHAN_W-1:0]         chan_reg;
    logic [FRAME_W-1:0]        frame_reg;

    logic [STATUS_W-1:0]       pend_status_reg, pend_status_next;
    logic signed [VALUE_W-1:0] pend_value_reg, pend_value_next;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    logic [CMD_W-1:0]          out_cmd_reg;

    check_t                    chk;
    div_status_t               div_st;
    logic signed [QUOT_W-1:0]  quot;
    logic                      div_start;
    logic                      ofs_we;
    logic signed [OFS_W-1:0]   ofs_wdata;
    logic                      in_take;
    logic                      out_load;

    logic                      good;
    logic [ERR_W:0]            err_inc;
    logic [ERR_W:0]            err_lim;
    logic signed [VALUE_W-1:0] sample;
    logic signed [QUOT_W-1:0]  sum_ext;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]          samples_inc;
    logic [CNT_W-1:0]          cnt_eff;

    afc_check u_check (
        .frame   (frame_reg),
        .channel (chan_reg),
        .offset  (offset_reg[chan_reg]),
        .result  (chk)
    );

    afc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (cnt_eff),
        .quotient (quot),
        .status   (div_st)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_PUT) && (!out_valid_reg || m_tready);

    assign good        = !chk.parity_err && !chk.addr_err;
    assign err_inc     = {1'b0, err_tries_reg} + 1'b1;
    assign err_lim     = {2'b00, retry_limit_reg} + 6'd2;
    assign sample      = good ? chk.reading : last_good_reg;
    assign sum_ext     = QUOT_W'(cal_sum_reg) + QUOT_W'(sample);
    assign samples_inc = cal_samples_reg + 1'b1;
    assign cnt_eff     = (cal_count_reg == '0) ? CNT_W'(1) : cal_count_reg;

    always_comb
    begin
        if (sum_ext > SUM_MAX)
            sum_sat = SUM_MAX[SUM_W-1:0];
        else if (sum_ext < SUM_MIN)
            sum_sat = SUM_MIN[SUM_W-1:0];
        else
            sum_sat = sum_ext[SUM_W-1:0];
    end

    always_comb
    begin
        if (quot > OFS_MAX)
            ofs_wdata = OFS_MAX[OFS_W-1:0];
        else if (quot < OFS_MIN)
            ofs_wdata = OFS_MIN[OFS_W-1:0];
        else
            ofs_wdata = quot[OFS_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        err_tries_next   = err_tries_reg;
        cal_sum_next     = cal_sum_reg;
        cal_samples_next = cal_samples_reg;
        last_good_next   = last_good_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        div_start        = 1'b0;
        ofs_we           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                pend_value_next = '0;
                state_next      = ST_PUT;
                if (!good && (err_inc < err_lim))
                begin
                    err_tries_next   = err_inc[ERR_W-1:0];
                    pend_status_next = STATUS_RETRY;
                end
                else
                begin
                    err_tries_next = '0;
                    if (!func_reg)
                    begin
                        if (good)
                        begin
                            pend_status_next = STATUS_OK;
                            pend_value_next  = chk.reading;
                        end
                        else if (chk.parity_err)
                            pend_status_next = STATUS_PARITY;
                        else
                            pend_status_next = STATUS_ADDR;
                    end
                    else
                    begin
                        if (good)
                            last_good_next = chk.reading;
                        if (samples_inc == '0 || samples_inc >= cnt_eff)
                        begin
                            div_start        = 1'b1;
                            cal_sum_next     = '0;
                            cal_samples_next = '0;
                            pend_status_next = STATUS_CAL_DONE;
                            state_next       = ST_DIV;
                        end
                        else
                        begin
                            cal_sum_next     = sum_sat;
                            cal_samples_next = samples_inc;
                            pend_status_next = STATUS_CAL_SAMPLE;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    ofs_we     = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            retry_limit_reg <= RETRY_LIMIT_RST;
            cal_count_reg   <= CAL_COUNT_RST;
            err_tries_reg   <= '0;
            cal_sum_reg     <= '0;
            cal_samples_reg <= '0;
            last_good_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 16; i++)
                offset_reg[i] <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            err_tries_reg   <= err_tries_next;
            cal_sum_reg     <= cal_sum_next;
            cal_samples_reg <= cal_samples_next;
            last_good_reg   <= last_good_next;
            out_valid_reg   <= out_valid_next;
            if (ofs_we)
                offset_reg[chan_reg] <= ofs_wdata;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RETRY_LIMIT: retry_limit_reg <= cfg_data[RETRY_W-1:0];
                    REG_CAL_COUNT:   cal_count_reg   <= cfg_data[CNT_W-1:0];
                    default:         retry_limit_reg <= retry_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg  <= s_tuser;
            chan_reg  <= s_tdata[CHAN_W-1:0];
            frame_reg <= s_tdata[CHAN_W+FRAME_W-1:CHAN_W];
        end
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_value_reg;
            out_cmd_reg    <= {CMD_PREFIX, chk.addr};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - CMD_W){1'b0}}, out_cmd_reg, out_value_reg};

    // divider only runs while the sequencer waits on it
    `AFC_ASSERT_NOW(a_idle_div_free, s_tready, !div_st.busy)
    `AFC_ASSERT_NOW(a_done_in_div, div_st.done, state_reg == ST_DIV)
    // a non-ok word carries a zero value
    `AFC_ASSERT_NOW(a_value_zero, m_tvalid && (m_tuser != STATUS_OK), m_tdata[VALUE_W-1:0] == '0)
    `AFC_ASSERT_NEXT(a_take_eval, s_tvalid && s_tready, state_reg == ST_EVAL)

endmodule

/* src/afc_check.sv */
// parity, address and reading decode of one converter word
// depends on afc_pkg
module afc_check (
    input  logic [afc_pkg::FRAME_W-1:0]       frame,
    input  logic [afc_pkg::CHAN_W-1:0]        channel,
    input  logic signed [afc_pkg::OFS_W-1:0]  offset,
    output afc_pkg::check_t                   result
);
    import afc_pkg::*;

    logic [VALUE_W-1:0]        mag;
    logic signed [VALUE_W-1:0] signed_mag;
    logic [ADDR_W-1:0]         addr;

    assign addr       = {1'b1, channel[0], channel[3:1]};
    assign mag        = {3'b000, frame[28:6]};
    assign signed_mag = frame[29] ? $signed(mag) : -$signed(mag);

    assign result.parity_err = ^frame;
    assign result.addr_err   = (frame[5:1] != addr);
    assign result.addr       = addr;
    assign result.reading    = signed_mag - $signed({offset[OFS_W-1], offset});

endmodule

/* src/afc_div.sv */
// serial restoring divider, one quotient bit per cycle, truncates toward zero
// depends on afc_pkg
module afc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [afc_pkg::SUM_W-1:0]  dividend,
    input  logic [afc_pkg::CNT_W-1:0]         divisor,
    output logic signed [afc_pkg::QUOT_W-1:0] quotient,
    output afc_pkg::div_status_t              status
);
    import afc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, q_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_W-1];
            q_next    = dividend[SUM_W-1] ? -dividend : dividend;
            rem_next  = '0;
            d_next    = divisor;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign quotient    = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
